// ----- rtl/lob_pkg.sv -----
// shared types, constants and codes of the limit order book matcher
package lob_pkg;

    localparam int BOOK_SLOTS = 64;
    localparam int PRICE_BITS = 16;
    localparam int QTY_BITS   = 24;
    localparam int ID_BITS    = 32;
    localparam int AGE_BITS   = 32;
    localparam int FILL_CAP   = 63;
    localparam int IDX_BITS   = (BOOK_SLOTS > 1) ? $clog2(BOOK_SLOTS) : 1;
    localparam int CNT_BITS   = IDX_BITS;
    localparam int FILL_BITS  = $clog2(FILL_CAP + 1);

    typedef logic [PRICE_BITS-1:0] t_price;
    typedef logic [QTY_BITS-1:0]   t_qty;
    typedef logic [ID_BITS-1:0]    t_id;
    typedef logic [AGE_BITS-1:0]   t_age;
    typedef logic [IDX_BITS-1:0]   t_idx;
    typedef logic [FILL_BITS-1:0]  t_fills;

    localparam logic [1:0] REQ_LIMIT  = 2'd0;
    localparam logic [1:0] REQ_MARKET = 2'd1;
    localparam logic [1:0] REQ_CANCEL = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_DROPPED   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVAL,
        ST_EMIT_FILL,
        ST_EMIT_SUM
    } t_state;

    typedef enum logic [1:0] {
        PH_MATCH,
        PH_CANCEL,
        PH_SUM
    } t_phase;

    // best resting order of one side, plus shares resting at its price
    typedef struct packed {
        logic   found;
        t_price price;
        t_age   age;
        t_idx   idx;
        t_qty   qty;
        t_id    owner;
        t_qty   sum;
    } t_best;

    // running scan result handed from cell to cell
    typedef struct packed {
        t_best bid;
        t_best ask;
        logic  free_found;
        t_idx  free_idx;
        logic  cxl_found;
        t_age  cxl_age;
        t_idx  cxl_idx;
    } t_carry;

    // slot write command from the sequencer
    typedef struct packed {
        logic   en;
        t_idx   idx;
        logic   load;
        logic   clr;
        logic   side;
        t_price price;
        t_qty   qty;
        t_id    owner;
        t_age   arrival;
    } t_slot_wr;

    typedef struct packed {
        logic       fill_valid;
        t_id        resting_id;
        t_id        incoming_id;
        t_price     fill_price;
        t_qty       fill_qty;
        t_qty       matched_total;
        logic [1:0] status;
        t_price     best_bid_price;
        t_qty       best_bid_qty;
        t_price     best_ask_price;
        t_qty       best_ask_qty;
        logic       last_result;
    } t_res;

endpackage

// ----- rtl/lob_if.sv -----
// request and result channel interfaces
interface lob_req_if;
    logic           valid;
    logic           ready;
    logic [1:0]     req_type;
    logic           side;
    lob_pkg::t_id    req_id;
    lob_pkg::t_price limit_price;
    lob_pkg::t_qty   order_qty;

    modport source (output valid, req_type, side, req_id, limit_price, order_qty,
                    input ready);
    modport sink (input valid, req_type, side, req_id, limit_price, order_qty,
                  output ready);
endinterface

interface lob_res_if;
    logic            valid;
    logic            ready;
    logic            fill_valid;
    lob_pkg::t_id    resting_id;
    lob_pkg::t_id    incoming_id;
    lob_pkg::t_price fill_price;
    lob_pkg::t_qty   fill_qty;
    lob_pkg::t_qty   matched_total;
    logic [1:0]      status;
    lob_pkg::t_price best_bid_price;
    lob_pkg::t_qty   best_bid_qty;
    lob_pkg::t_price best_ask_price;
    lob_pkg::t_qty   best_ask_qty;
    logic            last_result;

    modport source (output valid, fill_valid, resting_id, incoming_id, fill_price,
                    fill_qty, matched_total, status, best_bid_price, best_bid_qty,
                    best_ask_price, best_ask_qty, last_result,
                    input ready);
    modport sink (input valid, fill_valid, resting_id, incoming_id, fill_price,
                  fill_qty, matched_total, status, best_bid_price, best_bid_qty,
                  best_ask_price, best_ask_qty, last_result,
                  output ready);
endinterface

// ----- rtl/lob_cell.sv -----
// one book slot with its stage of the scan chain
module lob_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lob_pkg::t_idx     i_idx,
    input  lob_pkg::t_age     i_arrival,
    input  lob_pkg::t_id      i_cxl_id,
    input  lob_pkg::t_slot_wr i_wr,
    input  lob_pkg::t_carry   i_carry,
    output lob_pkg::t_carry   o_carry
);
    import lob_pkg::*;

    logic   r_valid;
    logic   r_side;
    t_price r_price;
    t_qty   r_qty;
    t_id    r_owner;
    t_age   r_arrival;
    t_carry r_carry;
    t_carry n_carry;
    t_age   w_age;

    function automatic t_best best_step(t_best b, logic s, t_price p, t_age a,
                                        t_idx ix, t_qty q, t_id ow);
        t_best           r;
        logic [QTY_BITS:0] sum;
        logic            take;
        r    = b;
        sum  = {1'b0, b.sum} + {1'b0, q};
        take = 1'b0;
        if (!b.found) begin
            take  = 1'b1;
            r.sum = q;
        end else if (p != b.price) begin
            // asks want lower, bids want higher
            take = s ? (p < b.price) : (p > b.price);
            if (take) begin
                r.sum = q;
            end
        end else begin
            r.sum = sum[QTY_BITS] ? '1 : sum[QTY_BITS-1:0];
            take  = a > b.age;
        end
        if (take) begin
            r.found = 1'b1;
            r.price = p;
            r.age   = a;
            r.idx   = ix;
            r.qty   = q;
            r.owner = ow;
        end
        return r;
    endfunction

    assign w_age = i_arrival - r_arrival;

    always_comb begin
        n_carry = i_carry;
        if (r_valid) begin
            if (r_side == SIDE_BUY) begin
                n_carry.bid = best_step(i_carry.bid, SIDE_BUY, r_price, w_age, i_idx,
                                        r_qty, r_owner);
            end else begin
                n_carry.ask = best_step(i_carry.ask, SIDE_SELL, r_price, w_age, i_idx,
                                        r_qty, r_owner);
            end
            if (r_owner == i_cxl_id && (!i_carry.cxl_found || w_age > i_carry.cxl_age)) begin
                n_carry.cxl_found = 1'b1;
                n_carry.cxl_age   = w_age;
                n_carry.cxl_idx   = i_idx;
            end
        end else if (!i_carry.free_found) begin
            n_carry.free_found = 1'b1;
            n_carry.free_idx   = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr.en && i_wr.idx == i_idx) begin
            if (i_wr.load) begin
                r_valid <= 1'b1;
            end else if (i_wr.clr) begin
                r_valid <= 1'b0;
            end else begin
                r_valid <= i_wr.qty != '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr.idx == i_idx) begin
            if (i_wr.load) begin
                r_side    <= i_wr.side;
                r_price   <= i_wr.price;
                r_qty     <= i_wr.qty;
                r_owner   <= i_wr.owner;
                r_arrival <= i_wr.arrival;
            end else if (!i_wr.clr) begin
                r_qty <= i_wr.qty;
            end
        end
    end

    assign o_carry = r_carry;

endmodule

// ----- rtl/limit_order_book_matcher.sv -----
// top level: sequencer, output register and the chain of book cells
//
// Single-symbol price-time priority order book. Requests arrive on i_req
// (limit, market or cancel); results leave on o_res. With fill reporting on
// (i_cfg_we / i_cfg_wdata) each trade gives one fill item, then every
// request ends with one summary item (last_result high) carrying the
// matched total, status and the best bid and ask after the request.
// Each book slot lives in one cell; a scan result ripples through the
// BOOK_SLOTS cells, one cell per cycle. A request costs one scan per
// fill, one more to end the match or find the cancel target, and one
// for the summary. One request is in work at a time; i_req.ready is
// high only between requests. Results sit in an output register, so the
// next request is taken while the summary waits; a stalled receiver
// holds the sequencer at the next fill or summary. Reset clears the
// book, the arrival counter and the fill enable; no clearing pass is needed.
module limit_order_book_matcher (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_cfg_we,
    input  logic   i_cfg_wdata,
    lob_req_if.sink   i_req,
    lob_res_if.source o_res
);
    import lob_pkg::*;

    t_state     r_state, n_state;
    t_phase     r_phase, n_phase;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic [1:0] r_type, n_type;
    logic       r_side, n_side;
    t_id        r_id, n_id;
    t_price     r_px, n_px;
    t_qty       r_qty, n_qty;
    t_qty       r_matched, n_matched;
    t_fills     r_fills, n_fills;
    logic [1:0] r_status, n_status;
    t_age       r_arrival, n_arrival;
    logic       r_emit;
    t_id        r_f_maker, n_f_maker;
    t_price     r_f_price, n_f_price;
    t_qty       r_f_qty, n_f_qty;
    logic       r_out_valid, n_out_valid;
    t_res       r_out, n_out;

    t_slot_wr   w_wr;
    t_carry     w_chain [BOOK_SLOTS+1];
    t_carry     w_res;
    t_best      w_opp;
    t_qty       w_q;
    logic       w_px_ok;
    logic       w_can_fill;
    logic       w_out_free;
    logic       w_acc;

    assign w_chain[0] = '0;

    for (genvar g = 0; g < BOOK_SLOTS; g++) begin : g_cell
        lob_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_idx     (t_idx'(g)),
            .i_arrival (r_arrival),
            .i_cxl_id  (r_id),
            .i_wr      (w_wr),
            .i_carry   (w_chain[g]),
            .o_carry   (w_chain[g+1])
        );
    end

    assign w_res      = w_chain[BOOK_SLOTS];
    assign w_opp      = (r_side == SIDE_BUY) ? w_res.ask : w_res.bid;
    assign w_q        = (r_qty < w_opp.qty) ? r_qty : w_opp.qty;
    assign w_px_ok    = (r_type == REQ_MARKET) ||
                        ((r_side == SIDE_BUY) ? (w_opp.price <= r_px) : (w_opp.price >= r_px));
    assign w_can_fill = (r_qty != '0) && (r_fills < t_fills'(FILL_CAP)) && w_opp.found && w_px_ok;
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_acc      = i_req.valid && i_req.ready;

    assign i_req.ready = (r_state == ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_type      = r_type;
        n_side      = r_side;
        n_id        = r_id;
        n_px        = r_px;
        n_qty       = r_qty;
        n_matched   = r_matched;
        n_fills     = r_fills;
        n_status    = r_status;
        n_arrival   = r_arrival;
        n_f_maker   = r_f_maker;
        n_f_price   = r_f_price;
        n_f_qty     = r_f_qty;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;
        w_wr        = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_type    = i_req.req_type;
                    n_side    = i_req.side;
                    n_id      = i_req.req_id;
                    n_px      = i_req.limit_price;
                    n_qty     = i_req.order_qty;
                    n_matched = '0;
                    n_fills   = '0;
                    n_status  = STAT_OK;
                    n_cnt     = '0;
                    n_state   = ST_SCAN;
                    case (i_req.req_type)
                        REQ_LIMIT, REQ_MARKET: n_phase = PH_MATCH;
                        REQ_CANCEL:            n_phase = PH_CANCEL;
                        default:               n_phase = PH_SUM;
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_cnt == CNT_BITS'(BOOK_SLOTS - 1)) begin
                    n_state = ST_EVAL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_EVAL: begin
                n_cnt   = '0;
                n_state = ST_SCAN;
                case (r_phase)
                    PH_MATCH: begin
                        if (w_can_fill) begin
                            w_wr.en   = 1'b1;
                            w_wr.idx  = w_opp.idx;
                            w_wr.qty  = w_opp.qty - w_q;
                            n_qty     = r_qty - w_q;
                            n_matched = r_matched + w_q;
                            n_fills   = r_fills + 1'b1;
                            n_f_maker = w_opp.owner;
                            n_f_price = w_opp.price;
                            n_f_qty   = w_q;
                            if (r_emit) begin
                                n_state = ST_EMIT_FILL;
                            end
                        end else begin
                            n_phase = PH_SUM;
                            if (r_qty != '0 && r_fills >= t_fills'(FILL_CAP)) begin
                                n_status = STAT_DROPPED;
                            end else if (r_qty != '0 && r_type == REQ_LIMIT) begin
                                if (w_res.free_found) begin
                                    w_wr.en      = 1'b1;
                                    w_wr.idx     = w_res.free_idx;
                                    w_wr.load    = 1'b1;
                                    w_wr.side    = r_side;
                                    w_wr.price   = r_px;
                                    w_wr.qty     = r_qty;
                                    w_wr.owner   = r_id;
                                    w_wr.arrival = r_arrival;
                                    n_arrival    = r_arrival + 1'b1;
                                end else begin
                                    n_status = STAT_DROPPED;
                                end
                            end
                        end
                    end
                    PH_CANCEL: begin
                        n_phase = PH_SUM;
                        if (w_res.cxl_found) begin
                            w_wr.en  = 1'b1;
                            w_wr.idx = w_res.cxl_idx;
                            w_wr.clr = 1'b1;
                        end else begin
                            n_status = STAT_NOT_FOUND;
                        end
                    end
                    default: begin
                        n_state = ST_EMIT_SUM;
                    end
                endcase
            end
            ST_EMIT_FILL: begin
                if (w_out_free) begin
                    n_out_valid       = 1'b1;
                    n_out             = '0;
                    n_out.fill_valid  = 1'b1;
                    n_out.resting_id  = r_f_maker;
                    n_out.incoming_id = r_id;
                    n_out.fill_price  = r_f_price;
                    n_out.fill_qty    = r_f_qty;
                    n_cnt             = '0;
                    n_state           = ST_SCAN;
                end
            end
            ST_EMIT_SUM: begin
                if (w_out_free) begin
                    n_out_valid          = 1'b1;
                    n_out                = '0;
                    n_out.matched_total  = r_matched;
                    n_out.status         = r_status;
                    n_out.best_bid_price = w_res.bid.found ? w_res.bid.price : '0;
                    n_out.best_bid_qty   = w_res.bid.found ? w_res.bid.sum : '0;
                    n_out.best_ask_price = w_res.ask.found ? w_res.ask.price : '0;
                    n_out.best_ask_qty   = w_res.ask.found ? w_res.ask.sum : '0;
                    n_out.last_result    = 1'b1;
                    n_state              = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_SUM;
            r_cnt       <= '0;
            r_arrival   <= '0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
            r_fills     <= '0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_arrival   <= n_arrival;
            r_out_valid <= n_out_valid;
            r_fills     <= n_fills;
            if (i_cfg_we) begin
                r_emit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_type    <= n_type;
        r_side    <= n_side;
        r_id      <= n_id;
        r_px      <= n_px;
        r_qty     <= n_qty;
        r_matched <= n_matched;
        r_status  <= n_status;
        r_f_maker <= n_f_maker;
        r_f_price <= n_f_price;
        r_f_qty   <= n_f_qty;
        r_out     <= n_out;
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.fill_valid     = r_out.fill_valid;
    assign o_res.resting_id     = r_out.resting_id;
    assign o_res.incoming_id    = r_out.incoming_id;
    assign o_res.fill_price     = r_out.fill_price;
    assign o_res.fill_qty       = r_out.fill_qty;
    assign o_res.matched_total  = r_out.matched_total;
    assign o_res.status         = r_out.status;
    assign o_res.best_bid_price = r_out.best_bid_price;
    assign o_res.best_bid_qty   = r_out.best_bid_qty;
    assign o_res.best_ask_price = r_out.best_ask_price;
    assign o_res.best_ask_qty   = r_out.best_ask_qty;
    assign o_res.last_result    = r_out.last_result;

    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fills <= t_fills'(FILL_CAP))
        else $error("fill count beyond cap");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_EVAL) |-> !w_wr.en)
        else $error("slot write outside evaluation");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_state == ST_SCAN))
        else $error("accepted item did not start a scan");

    a_summary_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT_SUM && w_out_free) |=> (r_state == ST_IDLE && r_out_valid))
        else $error("summary not loaded");

endmodule
